### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked on every rising edge outside reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### src/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg
// shared widths and types of the rgb to hsv pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package rth_pkg;

    localparam int CH_W  = 8;
    localparam int SAT_W = 16;
    localparam int HUE_W = 15;

    // sextant of the colour wheel, value equals its domain number
    typedef enum logic [2:0] {
        SEXT_RED_UP = 3'd0,
        SEXT_GRN_DN = 3'd1,
        SEXT_GRN_UP = 3'd2,
        SEXT_BLU_DN = 3'd3,
        SEXT_BLU_UP = 3'd4,
        SEXT_RED_DN = 3'd5
    } t_sext;

    typedef struct packed {
        logic [CH_W-1:0] hi;
        logic [CH_W-1:0] lo;
        logic [CH_W-1:0] mid;
        t_sext           sext;
    } t_sort;

    // full: middle channel ties the maximum, hue offset is one whole sextant
    typedef struct packed {
        logic [CH_W-1:0] bright;
        t_sext           sext;
        logic            grey;
        logic            full;
    } t_side;

endpackage

`default_nettype wire

### src/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// 8-bit rgb pixel to fixed-point hue, saturation and brightness
// each taken start reaches o_valid via input, sort, setup, divider, output registers
// throughput: one pixel per cycle, busy stays low, results cannot be held off
// depth is set by the two 16-stage bit-per-stage dividers run side by side
// reset clears the valid line only, so beats in flight are dropped
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rgb_to_hsv_converter
    import rth_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [CH_W-1:0]  i_red_in,
    input  wire logic [CH_W-1:0]  i_green_in,
    input  wire logic [CH_W-1:0]  i_blue_in,
    output logic                  o_valid,
    output logic      [HUE_W-1:0] o_hue_out,
    output logic      [SAT_W-1:0] o_sat_out,
    output logic      [CH_W-1:0]  o_bright_out
);

    localparam int HW        = HUE_FRAC_BITS + 3;
    localparam int DIV_DEPTH = SAT_W;
    localparam int PIPE_LEN  = DIV_DEPTH + 4;

    logic                   accept;
    logic [PIPE_LEN-1:0]    r_vld;

    logic [CH_W-1:0]        r_red;
    logic [CH_W-1:0]        r_grn;
    logic [CH_W-1:0]        r_blu;
    t_sort                  sort;

    logic [CH_W-1:0]        n_span;
    logic [CH_W+SAT_W-1:0]  n_sat_num;
    logic [CH_W-1:0]        r_span;
    logic [CH_W-1:0]        r_dist;
    logic [CH_W+SAT_W-1:0]  r_sat_num;
    t_side                  r_side [0:DIV_DEPTH];
    t_side                  n_side;

    logic [HUE_FRAC_BITS-1:0] frac;
    logic [SAT_W-1:0]         sat_q;

    logic                   n_up;
    logic [2:0]             n_dom;
    logic [HW-1:0]          n_base;
    logic [HW-1:0]          n_off;
    logic [HW-1:0]          n_sum;
    logic [HW-1:0]          n_hue;
    logic [HW+HUE_W-1:0]    n_hue_ext;
    logic [HUE_W-1:0]       r_hue;
    logic [SAT_W-1:0]       r_sat;
    logic [CH_W-1:0]        r_bright;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LEN-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_red <= i_red_in;
        r_grn <= i_green_in;
        r_blu <= i_blue_in;
    end

    rth_sort u_sort (
        .i_clk (i_clk),
        .i_red (r_red),
        .i_grn (r_grn),
        .i_blu (r_blu),
        .o_sort(sort)
    );

    // span*65535 written as span*65536 - span
    always_comb begin
        n_span      = sort.hi - sort.lo;
        n_sat_num   = {n_span, {SAT_W{1'b0}}} - {{SAT_W{1'b0}}, n_span};
        n_side.bright = sort.hi;
        n_side.sext   = sort.sext;
        n_side.grey   = (sort.hi == sort.lo);
        n_side.full   = (sort.mid == sort.hi);
    end

    always_ff @(posedge i_clk) begin
        r_span    <= n_span;
        r_dist    <= sort.mid - sort.lo;
        r_sat_num <= n_sat_num;
        r_side[0] <= n_side;
    end

    for (genvar k = 0; k < DIV_DEPTH; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            r_side[k+1] <= r_side[k];
        end
    end

    // divide by zero on grey or black beats is masked at the output
    // a distance equal to the span does not fit the quotient, the full flag covers it
    rth_div #(
        .W    (CH_W),
        .QW   (HUE_FRAC_BITS),
        .DEPTH(DIV_DEPTH)
    ) u_div_hue (
        .i_clk (i_clk),
        .i_rem (r_dist),
        .i_low ('0),
        .i_den (r_span),
        .o_quot(frac)
    );

    rth_div #(
        .W    (CH_W),
        .QW   (SAT_W),
        .DEPTH(DIV_DEPTH)
    ) u_div_sat (
        .i_clk (i_clk),
        .i_rem (r_sat_num[CH_W+SAT_W-1:SAT_W]),
        .i_low (r_sat_num[SAT_W-1:0]),
        .i_den (r_side[0].bright),
        .o_quot(sat_q)
    );

    always_comb begin
        case (r_side[DIV_DEPTH].sext)
            SEXT_RED_UP, SEXT_GRN_UP, SEXT_BLU_UP: begin
                n_up = 1'b1;
            end
            default: begin
                n_up = 1'b0;
            end
        endcase
        n_dom  = 3'(r_side[DIV_DEPTH].sext) + {2'b00, ~n_up};
        n_base = {n_dom, {HUE_FRAC_BITS{1'b0}}};
        if (r_side[DIV_DEPTH].full) begin
            n_off = {3'b001, {HUE_FRAC_BITS{1'b0}}};
        end else begin
            n_off = {3'b000, frac};
        end
        if (n_up) begin
            n_sum = n_base + n_off;
        end else begin
            n_sum = n_base - n_off;
        end
        // full-turn wrap when a falling offset truncates to zero
        if (n_sum >= {3'd6, {HUE_FRAC_BITS{1'b0}}}) begin
            n_hue = n_sum - {3'd6, {HUE_FRAC_BITS{1'b0}}};
        end else begin
            n_hue = n_sum;
        end
        n_hue_ext = {{HUE_W{1'b0}}, n_hue};
    end

    always_ff @(posedge i_clk) begin
        r_hue    <= r_side[DIV_DEPTH].grey ? '0 : n_hue_ext[HUE_W-1:0];
        r_sat    <= r_side[DIV_DEPTH].grey ? '0 : sat_q;
        r_bright <= r_side[DIV_DEPTH].bright;
    end

    assign o_valid      = r_vld[PIPE_LEN-1];
    assign o_hue_out    = r_hue;
    assign o_sat_out    = r_sat;
    assign o_bright_out = r_bright;

    `ASSERT_IMPLY(a_valid_from_start, i_clk, i_rst_n, o_valid, $past(start, PIPE_LEN),
        "result beat without a matching input beat")
    `ASSERT_IMPLY(a_grey_hue_zero, i_clk, i_rst_n, o_valid && o_sat_out == '0,
        o_hue_out == '0, "zero saturation with non-zero hue")
    `ASSERT_IMPLY(a_black_sat_zero, i_clk, i_rst_n, o_valid && o_bright_out == '0,
        o_sat_out == '0, "black pixel with non-zero saturation")
    `ASSERT_CLK(a_never_busy, i_clk, i_rst_n, !busy, "busy raised")

endmodule

`default_nettype wire

### src/rth_sort.sv
// ----------------------------------------------------------------------------
// rth_sort
// orders the three channels and picks the sextant, one registered stage
// ----------------------------------------------------------------------------
`default_nettype none

module rth_sort
    import rth_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic [CH_W-1:0] i_red,
    input  wire logic [CH_W-1:0] i_grn,
    input  wire logic [CH_W-1:0] i_blu,
    output t_sort                o_sort
);

    t_sort            r_sort;
    t_sort            n_sort;
    logic [CH_W+1:0]  n_total;
    logic [CH_W+1:0]  n_mid_ext;

    always_comb begin
        n_sort  = r_sort;
        n_total = {2'b00, i_red} + {2'b00, i_grn} + {2'b00, i_blu};
        // ties: red beats green, green beats blue
        if (i_red >= i_grn && i_red >= i_blu) begin
            n_sort.hi = i_red;
        end else if (i_grn >= i_blu) begin
            n_sort.hi = i_grn;
        end else begin
            n_sort.hi = i_blu;
        end
        if (i_red <= i_grn && i_red <= i_blu) begin
            n_sort.lo = i_red;
        end else if (i_grn <= i_blu) begin
            n_sort.lo = i_grn;
        end else begin
            n_sort.lo = i_blu;
        end
        n_mid_ext  = n_total - {2'b00, n_sort.hi} - {2'b00, n_sort.lo};
        n_sort.mid = n_mid_ext[CH_W-1:0];
        if (i_red == n_sort.hi) begin
            n_sort.sext = (n_sort.mid == i_grn) ? SEXT_RED_UP : SEXT_RED_DN;
        end else if (i_grn == n_sort.hi) begin
            n_sort.sext = (n_sort.mid == i_blu) ? SEXT_GRN_UP : SEXT_GRN_DN;
        end else begin
            n_sort.sext = (n_sort.mid == i_red) ? SEXT_BLU_UP : SEXT_BLU_DN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sort <= n_sort;
    end

    assign o_sort = r_sort;

endmodule

`default_nettype wire

### src/rth_div.sv
// ----------------------------------------------------------------------------
// rth_div
// pipelined restoring divider, one quotient bit per stage, padded to DEPTH
// ----------------------------------------------------------------------------
`default_nettype none

module rth_div #(
    parameter int W     = 8,
    parameter int QW    = 16,
    parameter int DEPTH = 16
) (
    input  wire logic          i_clk,
    input  wire logic [W-1:0]  i_rem,
    input  wire logic [QW-1:0] i_low,
    input  wire logic [W-1:0]  i_den,
    output logic      [QW-1:0] o_quot
);

    // i_rem must already be below i_den
    logic [W-1:0]  st_rem [0:DEPTH];
    logic [QW-1:0] st_low [0:DEPTH];
    logic [W-1:0]  st_den [0:DEPTH];
    logic [QW-1:0] st_quo [0:DEPTH];

    assign st_rem[0] = i_rem;
    assign st_low[0] = i_low;
    assign st_den[0] = i_den;
    assign st_quo[0] = '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_stage
        if (k < QW) begin : g_step
            logic [W:0]    n_sh;
            logic [W:0]    n_diff;
            logic          n_ge;
            logic [W-1:0]  r_rem;
            logic [QW-1:0] r_low;
            logic [W-1:0]  r_den;
            logic [QW-1:0] r_quo;

            always_comb begin
                n_sh   = {st_rem[k], st_low[k][QW-1]};
                n_diff = n_sh - {1'b0, st_den[k]};
                n_ge   = (n_sh >= {1'b0, st_den[k]});
            end

            always_ff @(posedge i_clk) begin
                r_rem <= n_ge ? n_diff[W-1:0] : n_sh[W-1:0];
                r_low <= {st_low[k][QW-2:0], 1'b0};
                r_den <= st_den[k];
                r_quo <= {st_quo[k][QW-2:0], n_ge};
            end

            assign st_rem[k+1] = r_rem;
            assign st_low[k+1] = r_low;
            assign st_den[k+1] = r_den;
            assign st_quo[k+1] = r_quo;
        end else begin : g_pad
            logic [QW-1:0] r_quo;

            always_ff @(posedge i_clk) begin
                r_quo <= st_quo[k];
            end

            assign st_rem[k+1] = st_rem[k];
            assign st_low[k+1] = st_low[k];
            assign st_den[k+1] = st_den[k];
            assign st_quo[k+1] = r_quo;
        end
    end

    assign o_quot = st_quo[DEPTH];

endmodule

`default_nettype wire
